/* hdl/pfnm_pkg.sv */
// Package for the four-neighbour mean relaxation filter.
// Holds the pixel and result types, register and item codes, and fixed constants.
// No dependencies.
package pfnm_pkg;

    // One stored pixel: colour and alpha bytes, red in byte 0, plus the pinned flag.
    typedef struct packed {
        logic            pinned;
        logic [3:0][7:0] rgba;
    } pixel_t;

    // One result pixel as it leaves the block.
    typedef struct packed {
        logic            last;
        logic [3:0][7:0] rgba;
    } result_t;

    // Register indexes on the configuration port.
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    localparam logic [10:0] FRAME_WIDTH_RESET  = 11'd640;
    localparam logic [12:0] FRAME_HEIGHT_RESET = 13'd480;

    // Item kinds on the input stream.
    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_DRAIN = 1'b1;

    // Colour channels, counted from red, that take the neighbour mean.
    localparam int COLOR_CHANNELS = 3;
    localparam int RGB_CHANNELS   = 3;
    localparam int ALPHA_BYTE     = 3;

    localparam logic [7:0] ALPHA_OPAQUE = 8'd255;
    localparam logic [7:0] ALPHA_FORCED = 8'd254;

    // floor(s / 3) = (s * 683) >> 11 for every s up to 765.
    localparam logic [9:0] RECIP_THREE = 10'd683;
    localparam int         RECIP_SHIFT = 11;

endpackage

/* hdl/pinned_four_neighbour_mean.sv */
// Top level of the four-neighbour mean relaxation filter.
// Depends on pfnm_pkg for pixel types, register codes and constants.
// Line buffers and the output stage are built inside this module.

// The block takes RGBA pixels in raster order and returns one relaxation sweep of the
// frame, one row late: each pixel item of row y (y >= 1) yields result pixel (x, y-1), and
// once all rows are in, each drain item yields the next pixel of the last row, the final
// one with tlast set, after which the block is ready for a new frame. Pinned pixels keep
// their colour; others take the truncated mean of the up, down, left and right neighbours
// that exist; alpha leaves as 255 when it was 255, else as 254. It sustains one item per
// clock while s_tready is high, working each item from two line buffers of MAX_WIDTH
// entries (one registered read each per item, with write forwarding) and a three-pixel
// window, and its result is registered. A two-entry output stage lets the slave side keep
// accepting while one result waits; s_tready drops only when both entries are full.
// The line buffers need no clearing pass after reset. Frame size registers may be changed
// between transactions, also mid-frame, and apply from the next item.
module pinned_four_neighbour_mean #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    // s_tdata, lowest bit up: red[7:0], green[15:8], blue[23:16], alpha[31:24],
    // pinned[32], zero padding[39:33].
    input  logic [39:0] s_tdata,
    // s_tuser: kind[0] (0 = pixel, 1 = drain).
    input  logic [0:0]  s_tuser,
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    // m_tdata, lowest bit up: out_red[7:0], out_green[15:8], out_blue[23:16],
    // out_alpha[31:24].
    output logic [31:0] m_tdata,
    // m_tlast: last_of_frame.
    output logic        m_tlast,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int EW = CW + 1;

    // Configuration registers.
    logic [10:0] cfg_width_reg;
    logic [12:0] cfg_height_reg;
    logic        cfg_write;
    logic        cfg_index;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = paddr[2];
    assign prdata    = (cfg_index == pfnm_pkg::REG_FRAME_HEIGHT) ? {19'd0, cfg_height_reg}
                                                                 : {21'd0, cfg_width_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_width_reg  <= pfnm_pkg::FRAME_WIDTH_RESET;
            cfg_height_reg <= pfnm_pkg::FRAME_HEIGHT_RESET;
        end else if (cfg_write) begin
            unique case (cfg_index)
                pfnm_pkg::REG_FRAME_WIDTH:  cfg_width_reg  <= pwdata[10:0];
                pfnm_pkg::REG_FRAME_HEIGHT: cfg_height_reg <= pwdata[12:0];
                default:                    cfg_width_reg  <= cfg_width_reg;
            endcase
        end
    end

    // Effective frame size: zero counts as one, width saturates at the buffer depth.
    logic [EW-1:0] eff_width;
    logic [12:0]   eff_height;

    always_comb begin
        if (cfg_width_reg == 11'd0) begin
            eff_width = EW'(1);
        end else if (32'(cfg_width_reg) > 32'(MAX_WIDTH)) begin
            eff_width = EW'(MAX_WIDTH);
        end else begin
            eff_width = EW'(cfg_width_reg);
        end
        eff_height = (cfg_height_reg == 13'd0) ? 13'd1 : cfg_height_reg;
    end

    // Position and window state.
    logic [CW-1:0]   col_reg;
    logic [12:0]     row_reg;
    pfnm_pkg::pixel_t c0_reg;          // row_center[x]
    pfnm_pkg::pixel_t center0_reg;     // row_center[0]
    pfnm_pkg::pixel_t left_above_reg;  // row_above[x-1]
    pfnm_pkg::pixel_t left_center_reg; // row_center[x-1]

    // Line buffers with registered reads and same-edge forwarding.
    pfnm_pkg::pixel_t above_mem  [MAX_WIDTH];
    pfnm_pkg::pixel_t center_mem [MAX_WIDTH];
    pfnm_pkg::pixel_t above_rd_reg;
    pfnm_pkg::pixel_t center_rd_reg;
    pfnm_pkg::pixel_t above_byp_data_reg;
    pfnm_pkg::pixel_t center_byp_data_reg;
    logic             above_byp_reg;
    logic             center_byp_reg;

    pfnm_pkg::pixel_t a0;  // row_above[x]
    pfnm_pkg::pixel_t c1;  // row_center[x+1]

    assign a0 = above_byp_reg  ? above_byp_data_reg  : above_rd_reg;
    assign c1 = center_byp_reg ? center_byp_data_reg : center_rd_reg;

    // Item decode.
    pfnm_pkg::pixel_t cur_px;
    logic             accept;
    logic             pix_phase;
    logic             step_pix;
    logic             step_drn;
    logic             advance;
    logic             row_end;
    logic [CW-1:0]    col_next;
    logic [CW-1:0]    center_rd_addr;
    logic             emit;

    assign cur_px    = pfnm_pkg::pixel_t'(s_tdata[32:0]);
    assign accept    = s_tvalid && s_tready;
    assign pix_phase = row_reg < eff_height;
    assign step_pix  = accept && pix_phase && (s_tuser[0] == pfnm_pkg::KIND_PIXEL);
    assign step_drn  = accept && !pix_phase && (s_tuser[0] == pfnm_pkg::KIND_DRAIN);
    assign advance   = step_pix || step_drn;
    assign row_end   = (EW'(col_reg) + EW'(1)) >= eff_width;
    assign col_next  = row_end ? '0 : col_reg + CW'(1);
    assign center_rd_addr = col_next + CW'(1);
    assign emit      = (step_pix && (row_reg != 13'd0)) || step_drn;

    always_ff @(posedge aclk) begin
        if (step_pix) begin
            above_mem[col_reg]  <= c0_reg;
            center_mem[col_reg] <= cur_px;
        end
        if (advance) begin
            above_rd_reg  <= above_mem[col_next];
            center_rd_reg <= center_mem[center_rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            above_byp_reg       <= step_pix && (col_reg == col_next);
            above_byp_data_reg  <= c0_reg;
            center_byp_reg      <= step_pix && (col_reg == center_rd_addr);
            center_byp_data_reg <= cur_px;
            if (!row_end) begin
                c0_reg <= c1;
            end else if (step_pix && (col_reg == '0)) begin
                c0_reg <= cur_px;
            end else begin
                c0_reg <= center0_reg;
            end
            left_above_reg  <= step_pix ? c0_reg : a0;
            left_center_reg <= step_pix ? cur_px : c0_reg;
        end
        if (step_pix && (col_reg == '0)) begin
            center0_reg <= cur_px;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (advance) begin
            col_reg <= col_next;
            if (row_end) begin
                row_reg <= step_pix ? row_reg + 13'd1 : 13'd0;
            end
        end
    end

    // Neighbour mean over the window.
    logic             has_up;
    logic             has_down;
    logic             has_left;
    logic             has_right;
    logic [2:0]       nb_count;
    pfnm_pkg::pixel_t left_px;
    logic [2:0][9:0]  ch_sum;
    pfnm_pkg::result_t result;

    function automatic logic [7:0] nb_mean(input logic [9:0] sum, input logic [2:0] cnt,
                                           input logic [7:0] keep);
        logic [19:0] prod;
        logic [7:0]  mean;
        prod = 20'(sum) * 20'(pfnm_pkg::RECIP_THREE);
        unique case (cnt)
            3'd1:    mean = sum[7:0];
            3'd2:    mean = sum[8:1];
            3'd3:    mean = prod[pfnm_pkg::RECIP_SHIFT +: 8];
            3'd4:    mean = sum[9:2];
            default: mean = keep;
        endcase
        return mean;
    endfunction

    always_comb begin
        has_up    = step_pix ? (row_reg >= 13'd2) : (eff_height >= 13'd2);
        has_down  = step_pix;
        has_left  = col_reg != '0;
        has_right = (EW'(col_reg) + EW'(1)) < eff_width;
        nb_count  = 3'(has_up) + 3'(has_down) + 3'(has_left) + 3'(has_right);
        left_px   = step_pix ? left_above_reg : left_center_reg;

        result.last = step_drn && row_end;
        for (int ch = 0; ch < pfnm_pkg::RGB_CHANNELS; ch++) begin
            ch_sum[ch] = (has_up    ? 10'(a0.rgba[ch])      : 10'd0)
                       + (has_down  ? 10'(cur_px.rgba[ch])  : 10'd0)
                       + (has_left  ? 10'(left_px.rgba[ch]) : 10'd0)
                       + (has_right ? 10'(c1.rgba[ch])      : 10'd0);
            if ((ch < pfnm_pkg::COLOR_CHANNELS) && !c0_reg.pinned) begin
                result.rgba[ch] = nb_mean(ch_sum[ch], nb_count, c0_reg.rgba[ch]);
            end else begin
                result.rgba[ch] = c0_reg.rgba[ch];
            end
        end
        result.rgba[pfnm_pkg::ALPHA_BYTE] =
            (c0_reg.rgba[pfnm_pkg::ALPHA_BYTE] == pfnm_pkg::ALPHA_OPAQUE)
                ? pfnm_pkg::ALPHA_OPAQUE : pfnm_pkg::ALPHA_FORCED;
    end

    // Two-entry output stage: the output register and a skid entry behind it.
    pfnm_pkg::result_t out_reg;
    pfnm_pkg::result_t skid_reg;
    logic              out_valid_reg;
    logic              skid_valid_reg;
    logic              pop;

    assign s_tready = !skid_valid_reg;
    assign pop      = out_valid_reg && m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg.rgba;
    assign m_tlast  = out_reg.last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (pop) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end else if (emit) begin
            if (!out_valid_reg || pop) begin
                out_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (pop) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (pop) begin
                out_reg <= skid_reg;
            end
        end else if (emit) begin
            if (!out_valid_reg || pop) begin
                out_reg <= result;
            end else begin
                skid_reg <= result;
            end
        end
    end

    // The skid entry is only ever filled behind a waiting result.
    assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry holds a result while the output register is empty");

    // The final drain transaction returns the counters to the start of a frame.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (step_drn && row_end) |=> (row_reg == 13'd0 && col_reg == '0))
        else $error("frame did not restart after its last pixel");

    // A completed pixel row moves the row count on by exactly one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (step_pix && row_end) |=> (row_reg == $past(row_reg) + 13'd1 && col_reg == '0))
        else $error("row count did not advance by one at the end of a row");

endmodule

/* dv/pfnm_sweep_checker.sv */
`timescale 1ns / 100ps
// Scoreboard for pinned_four_neighbour_mean: follows the frame size registers on the
// configuration port, predicts every result pixel of the relaxation sweep and compares it.
// Depends on pfnm_pkg for the pixel and result types and the fixed constants.
module pfnm_sweep_checker #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,
    input  logic [0:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    input  logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          mismatches,
    output int          outstanding
);

    // Neighbor slots in the window handed to the mean.
    localparam int UP    = 0;
    localparam int DOWN  = 1;
    localparam int LEFT  = 2;
    localparam int RIGHT = 3;

    pfnm_pkg::pixel_t  above_line [MAX_WIDTH];
    pfnm_pkg::pixel_t  center_line[MAX_WIDTH];
    int                column;
    int                row;
    logic [10:0]       width_reg;
    logic [12:0]       height_reg;
    pfnm_pkg::result_t expected_pixels[$];
    int                bad = 0;
    int                results_seen = 0;

    function automatic pfnm_pkg::result_t relax_pixel(input pfnm_pkg::pixel_t middle,
                                                      input pfnm_pkg::pixel_t [3:0] nb,
                                                      input logic [3:0] has,
                                                      input logic last);
        pfnm_pkg::result_t r;
        int      n;
        int      sum;
        int      k;
        int      ch;
        n = 0;
        for (k = 0; k < 4; k++)
            if (has[k]) n++;
        r.rgba = middle.rgba;
        r.last = last;
        if (!middle.pinned && n != 0) begin
            for (ch = 0; ch < pfnm_pkg::RGB_CHANNELS; ch++) begin
                if (ch < pfnm_pkg::COLOR_CHANNELS) begin
                    sum = 0;
                    for (k = 0; k < 4; k++)
                        if (has[k]) sum += nb[k].rgba[ch];
                    r.rgba[ch] = 8'(sum / n);
                end
            end
        end
        r.rgba[pfnm_pkg::ALPHA_BYTE] =
            (r.rgba[pfnm_pkg::ALPHA_BYTE] == pfnm_pkg::ALPHA_OPAQUE)
                ? pfnm_pkg::ALPHA_OPAQUE : pfnm_pkg::ALPHA_FORCED;
        return r;
    endfunction

    // Advances the sweep by one accepted transaction and queues the pixel it releases.
    task automatic take_item(input logic kind, input pfnm_pkg::pixel_t cur);
        int                     w;
        int                     h;
        int                     x;
        int                     y;
        pfnm_pkg::pixel_t [3:0] nb;
        logic             [3:0] has;
        w = (width_reg == 0) ? 1 : (width_reg > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg);
        h = (height_reg == 0) ? 1 : int'(height_reg);
        x = (column >= MAX_WIDTH) ? MAX_WIDTH - 1 : column;
        y = row;
        nb = '0;
        has = '0;
        if (y < h) begin
            if (kind == pfnm_pkg::KIND_PIXEL) begin
                // Row y arrives while row y-1 is finished: cur is its down neighbor.
                if (y >= 1) begin
                    if (y >= 2) begin
                        has[UP] = 1'b1;
                        nb[UP] = above_line[x];
                    end
                    has[DOWN] = 1'b1;
                    nb[DOWN] = cur;
                    if (x > 0) begin
                        has[LEFT] = 1'b1;
                        nb[LEFT] = above_line[x - 1];
                    end
                    if (x + 1 < w) begin
                        has[RIGHT] = 1'b1;
                        nb[RIGHT] = center_line[x + 1];
                    end
                    expected_pixels.push_back(relax_pixel(center_line[x], nb, has, 1'b0));
                end
                above_line[x] = center_line[x];
                center_line[x] = cur;
                if (x + 1 >= w) begin
                    column = 0;
                    row = y + 1;
                end else begin
                    column = x + 1;
                end
            end
        end else if (kind == pfnm_pkg::KIND_DRAIN) begin
            if (h >= 2) begin
                has[UP] = 1'b1;
                nb[UP] = above_line[x];
            end
            if (x > 0) begin
                has[LEFT] = 1'b1;
                nb[LEFT] = center_line[x - 1];
            end
            if (x + 1 < w) begin
                has[RIGHT] = 1'b1;
                nb[RIGHT] = center_line[x + 1];
            end
            expected_pixels.push_back(relax_pixel(center_line[x], nb, has, x + 1 >= w));
            if (x + 1 >= w) begin
                column = 0;
                row = 0;
            end else begin
                column = x + 1;
            end
        end
    endtask

    task automatic check_result();
        pfnm_pkg::result_t want;
        logic    wrong;
        int      i;
        results_seen++;
        if (expected_pixels.size() == 0) begin
            bad++;
            if (bad <= 10)
                $display("checker: result %0d (rgba %h last %b) arrived with none expected",
                         results_seen, m_tdata, m_tlast);
        end else begin
            want = expected_pixels.pop_front();
            wrong = 1'b0;
            for (i = 0; i < 4; i++)
                if (m_tdata[8*i +: 8] !== want.rgba[i]) wrong = 1'b1;
            if (m_tlast !== want.last) wrong = 1'b1;
            if (wrong) begin
                bad++;
                if (bad <= 10)
                    $display({"checker: result %0d expected r %0d g %0d b %0d a %0d last %b, ",
                              "got r %0d g %0d b %0d a %0d last %b"}, results_seen,
                             want.rgba[0], want.rgba[1], want.rgba[2], want.rgba[3], want.last,
                             m_tdata[7:0], m_tdata[15:8], m_tdata[23:16], m_tdata[31:24],
                             m_tlast);
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            column = 0;
            row = 0;
            width_reg = pfnm_pkg::FRAME_WIDTH_RESET;
            height_reg = pfnm_pkg::FRAME_HEIGHT_RESET;
            expected_pixels.delete();
        end else begin
            // Results leave after their item, so check them before queueing new ones.
            if (m_tvalid && m_tready)
                check_result();
            if (s_tvalid && s_tready)
                take_item(s_tuser[0], pfnm_pkg::pixel_t'(s_tdata[32:0]));
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == pfnm_pkg::REG_FRAME_HEIGHT)
                    height_reg = pwdata[12:0];
                else
                    width_reg = pwdata[10:0];
            end
        end
        outstanding <= expected_pixels.size();
        mismatches <= bad;
    end

endmodule

/* dv/tb.sv */
`timescale 1ns / 100ps
// Testbench top for pinned_four_neighbour_mean: drives pixel and drain transactions,
// frame size writes and result back-pressure, and gives the verdict.
// Depends on pfnm_pkg, the block and pfnm_sweep_checker.
module tb;

    localparam int MAX_WIDTH    = 1024;
    localparam int RANDOM_ITEMS = 1400;

    localparam int PATTERN_RANDOM   = 0;
    localparam int PATTERN_EXTREMES = 1;

    localparam int NOISE_NONE     = 0;
    localparam int NOISE_RANDOM   = 1;
    localparam int NOISE_DIRECTED = 2;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic [0:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        m_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          mismatches;
    int          outstanding;

    int send_calm = 0;
    int sink_calm = 0;
    int frames_run = 0;
    int items_sent = 0;

    pinned_four_neighbour_mean #(.MAX_WIDTH(MAX_WIDTH)) uut (.*);

    pfnm_sweep_checker #(.MAX_WIDTH(MAX_WIDTH)) sweep_check (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Per-transaction wait, with occasional stretches of back-to-back traffic.
    function automatic int pick_wait(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
            calm = $urandom_range(8, 48);
        return $urandom_range(0, 13);
    endfunction

    function automatic int used_width(input logic [31:0] v);
        int w;
        w = v[10:0];
        if (w == 0) w = 1;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        return w;
    endfunction

    function automatic int used_height(input logic [31:0] v);
        int h;
        h = v[12:0];
        if (h == 0) h = 1;
        return h;
    endfunction

    function automatic pfnm_pkg::pixel_t make_pixel(input int pattern, input int i);
        pfnm_pkg::pixel_t p;
        p.rgba = $urandom();
        p.pinned = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 3) == 0)
            p.rgba[pfnm_pkg::ALPHA_BYTE] = pfnm_pkg::ALPHA_OPAQUE;
        if (pattern == PATTERN_EXTREMES) begin
            p.rgba[0] = i[0] ? 8'hFF : 8'h00;
            p.rgba[1] = i[1] ? 8'hFF : 8'h00;
            p.rgba[2] = i[2] ? 8'hFF : 8'h00;
            case (i % 4)
                0: p.rgba[pfnm_pkg::ALPHA_BYTE] = 8'h00;
                1: p.rgba[pfnm_pkg::ALPHA_BYTE] = 8'h80;
                2: p.rgba[pfnm_pkg::ALPHA_BYTE] = pfnm_pkg::ALPHA_FORCED;
                default: p.rgba[pfnm_pkg::ALPHA_BYTE] = pfnm_pkg::ALPHA_OPAQUE;
            endcase
            p.pinned = (i % 3 == 1);
        end
        return p;
    endfunction

    task automatic send_item(input logic kind, input pfnm_pkg::pixel_t px);
        int n;
        n = pick_wait(send_calm);
        if (n > 0) begin
            s_tvalid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {7'b0, px};
        s_tuser <= kind;
        do @(posedge aclk); while (s_tready !== 1'b1);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge aclk);
    endtask

    // Stop sending and wait until every predicted pixel is out and the block has gone quiet.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic run_frame(input logic [31:0] w_val, input logic [31:0] h_val,
                             input int pattern, input int noise);
        int w;
        int h;
        int i;
        w = used_width(w_val);
        h = used_height(h_val);
        settle();
        write_reg(pfnm_pkg::REG_FRAME_WIDTH, w_val);
        write_reg(pfnm_pkg::REG_FRAME_HEIGHT, h_val);
        // Stray drains while rows are still coming in must be ignored.
        for (i = 0; i < w * h; i++) begin
            if ((noise == NOISE_RANDOM && $urandom_range(0, 15) == 0) ||
                (noise == NOISE_DIRECTED && i == 0))
                send_item(pfnm_pkg::KIND_DRAIN, make_pixel(PATTERN_RANDOM, i));
            send_item(pfnm_pkg::KIND_PIXEL, make_pixel(pattern, i));
        end
        // Likewise stray pixels once the last row is being flushed.
        for (i = 0; i < w; i++) begin
            if ((noise == NOISE_RANDOM && $urandom_range(0, 15) == 0) ||
                (noise == NOISE_DIRECTED && i == 0))
                send_item(pfnm_pkg::KIND_PIXEL, make_pixel(PATTERN_RANDOM, i));
            send_item(pfnm_pkg::KIND_DRAIN, make_pixel(PATTERN_RANDOM, i));
        end
        frames_run++;
        items_sent += w * h + w;
    endtask

    initial begin : result_sink
        int n;
        m_tready <= 1'b0;
        do @(posedge aclk); while (aresetn !== 1'b1);
        forever begin
            n = pick_wait(sink_calm);
            if (n > 0) begin
                m_tready <= 1'b0;
                repeat (n) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid === 1'b1 && m_tready === 1'b1));
        end
    end

    initial begin
        #20_000_000;
        $display("tb NOT OK");
        $finish;
    end

    initial begin : stimulus
        int i;
        int w;
        int h;
        int random_start;
        aresetn <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Saturated channels, every alpha class, pinned pixels in the middle column, free pixels on all borders.
        run_frame(3, 3, PATTERN_EXTREMES, NOISE_DIRECTED);
        // Zero size reads as a single pixel with no neighbors.
        run_frame(0, 0, PATTERN_EXTREMES, NOISE_NONE);

        // Narrow the frame mid-row: column 2 then lies past the new last column.
        settle();
        write_reg(pfnm_pkg::REG_FRAME_WIDTH, 4);
        write_reg(pfnm_pkg::REG_FRAME_HEIGHT, 3);
        for (i = 0; i < 6; i++)
            send_item(pfnm_pkg::KIND_PIXEL, make_pixel(PATTERN_RANDOM, i));
        settle();
        write_reg(pfnm_pkg::REG_FRAME_WIDTH, 2);
        for (i = 0; i < 3; i++)
            send_item(pfnm_pkg::KIND_PIXEL, make_pixel(PATTERN_RANDOM, i));
        for (i = 0; i < 2; i++)
            send_item(pfnm_pkg::KIND_DRAIN, make_pixel(PATTERN_RANDOM, i));
        frames_run++;
        items_sent += 11;

        random_start = items_sent;
        while (items_sent - random_start < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0: begin
                    w = $urandom_range(9, 48);
                    h = $urandom_range(1, 3);
                end
                1: begin
                    w = $urandom_range(0, 1);
                    h = $urandom_range(0, 12);
                end
                default: begin
                    w = $urandom_range(1, 8);
                    h = $urandom_range(1, 6);
                end
            endcase
            // Bits above each register are junk and must be dropped.
            run_frame(w | ($urandom() << 11), h | ($urandom() << 13), PATTERN_RANDOM,
                      NOISE_RANDOM);
        end

        settle();
        repeat (16) @(posedge aclk);
        $display("tb: %0d frames, %0d pixel and drain transactions, sizes 1x1 to 48 wide",
                 frames_run, items_sent);
        $display("tb: and 12 tall, with stray items, mid-frame resize and back-pressure");
        if (mismatches == 0 && outstanding == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
